### hdl/affine_quantize_dequantize_macros.svh
// Assertion macros for the affine quantize and dequantize block.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef AFFINE_QUANTIZE_DEQUANTIZE_MACROS_SVH
`define AFFINE_QUANTIZE_DEQUANTIZE_MACROS_SVH
`ifndef SYNTHESIS
`define AQD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AQD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AQD_ASSERT_NOW(label, ante, cons)
`define AQD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/aqd_pkg.sv
// Shared types and constants of the affine quantize and dequantize block.
// No dependencies.
`timescale 1ns / 1ps
package aqd_pkg;

  typedef struct packed {
    logic [31:0] data_in;
    logic        last_in;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        scale_error;
    logic        was_clamped;
    logic        last_out;
  } out_word_t;

  // Per-word control that travels down the pipeline with the data.
  typedef struct packed {
    logic dq;
    logic wide;
    logic err;
    logic last;
  } ctl_t;

  localparam logic [1:0] MODE_Q8  = 2'd0;
  localparam logic [1:0] MODE_Q16 = 2'd1;
  localparam logic [1:0] MODE_DQ  = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SCALE = 2'd1;
  localparam logic [1:0] REG_RECIP = 2'd2;
  localparam logic [1:0] REG_ZERO  = 2'd3;

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

  localparam logic signed [32:0] Q8_LO  = -33'sd128;
  localparam logic signed [32:0] Q8_HI  = 33'sd127;
  localparam logic signed [32:0] Q16_LO = -33'sd32768;
  localparam logic signed [32:0] Q16_HI = 33'sd32767;

  localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

endpackage

### hdl/affine_quantize_dequantize.sv
// Affine quantize / dequantize: a word accepted at one rising edge passes through six
// register stages (five pipeline stages and the output register) to out_valid; throughput
// is one word per cycle while out_stall is low. Stalls back up stage by stage, so
// bubbles are squeezed out. rst_n is synchronous and active low; it empties the pipeline
// and loads the register defaults (mode int8, scale and reciprocal 1.0, zero point 0).
// Depends on aqd_pkg and affine_quantize_dequantize_macros.svh.
`timescale 1ns / 1ps
`include "affine_quantize_dequantize_macros.svh"
module affine_quantize_dequantize (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  aqd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aqd_pkg::out_word_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Leading zero counts used by the int-to-float and normalize steps.
  function automatic logic [3:0] lzc16(input logic [15:0] v);
    logic [3:0] n;
    logic       f;
    n = '0;
    f = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (!f) begin
        if (v[i]) f = 1'b1;
        else n = n + 4'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       f;
    n = '0;
    f = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!f) begin
        if (v[i]) f = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access cycle; the port never
  // waits. Software must only write them while the pipeline is empty; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [1:0]         conv_mode_r;
  logic [31:0]        scale_r;
  logic [31:0]        recip_r;
  logic signed [15:0] zp_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_mode_r <= aqd_pkg::MODE_Q8;
      scale_r     <= aqd_pkg::FP_ONE;
      recip_r     <= aqd_pkg::FP_ONE;
      zp_r        <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        aqd_pkg::REG_MODE:  conv_mode_r <= pwdata[1:0];
        aqd_pkg::REG_SCALE: scale_r     <= pwdata;
        aqd_pkg::REG_RECIP: recip_r     <= pwdata;
        aqd_pkg::REG_ZERO:  zp_r        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      aqd_pkg::REG_MODE:  prdata = {30'b0, conv_mode_r};
      aqd_pkg::REG_SCALE: prdata = scale_r;
      aqd_pkg::REG_RECIP: prdata = recip_r;
      aqd_pkg::REG_ZERO:  prdata = {16'b0, zp_r};
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. Each stage moves when it is empty or the stage after it moves,
  // so a stall only holds the words that actually have nowhere to go.
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic adv1, adv2, adv3, adv4, adv5, adv6;

  assign adv6     = !out_valid_r || !out_stall;
  assign adv5     = !v5_r || adv6;
  assign adv4     = !v4_r || adv5;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
      if (adv6) out_valid_r <= v5_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pick the multiplier operands. Quantizing multiplies the input
  // (a NaN input becomes +0) by the reciprocal. Dequantizing multiplies the
  // scale by q minus the zero offset, which is an exact integer turned into a
  // float here.
  // ---------------------------------------------------------------------------
  logic [7:0]         s1_q;
  logic signed [16:0] s1_diff;
  logic [16:0]        s1_neg;
  logic [15:0]        s1_mag;
  logic [3:0]         s1_lz;
  logic [15:0]        s1_magn;
  logic [7:0]         s1_dexp;
  logic [31:0]        s1_dfl;
  logic [31:0]        s1_x;
  logic               s1_le0;
  aqd_pkg::ctl_t      s1_ctl_nxt;
  logic [31:0]        s1_a_nxt, s1_b_nxt;
  logic [31:0]        s1_a_r, s1_b_r;
  aqd_pkg::ctl_t      s1_ctl_r;

  always_comb begin
    s1_q    = in_data.data_in[7:0];
    s1_diff = $signed({{9{s1_q[7]}}, s1_q}) - $signed({zp_r[15], zp_r});
    s1_neg  = 17'd0 - s1_diff;
    s1_mag  = s1_diff[16] ? s1_neg[15:0] : s1_diff[15:0];
    s1_lz   = lzc16(s1_mag);
    s1_magn = s1_mag << s1_lz;
    s1_dexp = 8'd142 - {4'b0, s1_lz};
    s1_dfl  = (s1_mag == 16'd0) ? 32'd0 : {s1_diff[16], s1_dexp, s1_magn[14:0], 8'b0};

    if (in_data.data_in[30:23] == 8'hFF && in_data.data_in[22:0] != 23'd0) s1_x = '0;
    else s1_x = in_data.data_in;

    // Scale <= 0 covers both zeros and every negative value except NaN.
    s1_le0 = (scale_r[30:0] == 31'd0) ||
             (scale_r[31] && !(scale_r[30:23] == 8'hFF && scale_r[22:0] != 23'd0));

    s1_ctl_nxt.dq   = conv_mode_r[1];
    s1_ctl_nxt.wide = (conv_mode_r == aqd_pkg::MODE_Q16);
    s1_ctl_nxt.err  = !conv_mode_r[1] && s1_le0;
    s1_ctl_nxt.last = in_data.last_in;

    s1_a_nxt = conv_mode_r[1] ? scale_r : s1_x;
    s1_b_nxt = conv_mode_r[1] ? s1_dfl  : recip_r;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_a_r   <= s1_a_nxt;
      s1_b_r   <= s1_b_nxt;
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: unpack both operands and multiply the significands.
  // ---------------------------------------------------------------------------
  logic [7:0]    s2_ea, s2_eb;
  logic [23:0]   s2_ma, s2_mb;
  logic          s2_an, s2_bn, s2_ai, s2_bi, s2_az, s2_bz;
  logic [47:0]   s2_p_nxt, s2_p_r;
  logic [8:0]    s2_es_nxt, s2_es_r;
  logic          s2_sign_r, s2_nan_r, s2_inf_r, s2_zero_r;
  aqd_pkg::ctl_t s2_ctl_r;

  always_comb begin
    s2_ea = (s1_a_r[30:23] == 8'd0) ? 8'd1 : s1_a_r[30:23];
    s2_eb = (s1_b_r[30:23] == 8'd0) ? 8'd1 : s1_b_r[30:23];
    s2_ma = {|s1_a_r[30:23], s1_a_r[22:0]};
    s2_mb = {|s1_b_r[30:23], s1_b_r[22:0]};
    s2_an = (s1_a_r[30:23] == 8'hFF) && (s1_a_r[22:0] != 23'd0);
    s2_bn = (s1_b_r[30:23] == 8'hFF) && (s1_b_r[22:0] != 23'd0);
    s2_ai = (s1_a_r[30:23] == 8'hFF) && (s1_a_r[22:0] == 23'd0);
    s2_bi = (s1_b_r[30:23] == 8'hFF) && (s1_b_r[22:0] == 23'd0);
    s2_az = (s1_a_r[30:0] == 31'd0);
    s2_bz = (s1_b_r[30:0] == 31'd0);
    s2_p_nxt  = s2_ma * s2_mb;
    s2_es_nxt = {1'b0, s2_ea} + {1'b0, s2_eb};
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_p_r    <= s2_p_nxt;
      s2_es_r   <= s2_es_nxt;
      s2_sign_r <= s1_a_r[31] ^ s1_b_r[31];
      s2_nan_r  <= s2_an | s2_bn | (s2_ai & s2_bz) | (s2_az & s2_bi);
      s2_inf_r  <= s2_ai | s2_bi;
      s2_zero_r <= s2_az | s2_bz;
      s2_ctl_r  <= s1_ctl_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: normalize the product so its leading one sits in bit 47.
  // ---------------------------------------------------------------------------
  logic [5:0]         s3_lz;
  logic [47:0]        s3_n_nxt, s3_n_r;
  logic signed [10:0] s3_e_nxt, s3_e_r;
  logic               s3_sign_r, s3_nan_r, s3_inf_r, s3_zero_r;
  aqd_pkg::ctl_t      s3_ctl_r;

  always_comb begin
    s3_lz    = lzc48(s2_p_r);
    s3_n_nxt = s2_p_r << s3_lz;
    s3_e_nxt = $signed({2'b00, s2_es_r}) - 11'sd126 - $signed({5'b0, s3_lz});
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_n_r    <= s3_n_nxt;
      s3_e_r    <= s3_e_nxt;
      s3_sign_r <= s2_sign_r;
      s3_nan_r  <= s2_nan_r;
      s3_inf_r  <= s2_inf_r;
      s3_zero_r <= s2_zero_r;
      s3_ctl_r  <= s2_ctl_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: denormalize tiny results, round to nearest even and pack. A carry
  // out of the rounding walks into the exponent, which also produces infinity.
  // ---------------------------------------------------------------------------
  logic [10:0]   s4_rs;
  logic [47:0]   s4_sh;
  logic          s4_ext, s4_sub, s4_ovf, s4_rup;
  logic [7:0]    s4_expf;
  logic [30:0]   s4_mag;
  logic [31:0]   s4_pf_nxt, s4_pf_r;
  aqd_pkg::ctl_t s4_ctl_r;

  always_comb begin
    s4_sub = (s3_e_r < 11'sd1);
    s4_ovf = (s3_e_r > 11'sd254);
    s4_rs  = 11'sd1 - s3_e_r;
    if (!s4_sub) begin
      s4_sh  = s3_n_r;
      s4_ext = 1'b0;
    end else if (s4_rs >= 11'd48) begin
      s4_sh  = '0;
      s4_ext = |s3_n_r;
    end else begin
      s4_sh  = s3_n_r >> s4_rs[5:0];
      s4_ext = |(s3_n_r & ~({48{1'b1}} << s4_rs[5:0]));
    end
    s4_expf = s4_sub ? 8'd0 : s3_e_r[7:0];
    s4_rup  = s4_sh[23] & ((|s4_sh[22:0]) | s4_ext | s4_sh[24]);
    s4_mag  = {s4_expf, s4_sh[46:24]} + {30'd0, s4_rup};

    if (s3_nan_r) s4_pf_nxt = aqd_pkg::FP_QNAN;
    else if (s3_inf_r || (s4_ovf && !s3_zero_r)) s4_pf_nxt = {s3_sign_r, 8'hFF, 23'd0};
    else if (s3_zero_r) s4_pf_nxt = {s3_sign_r, 31'd0};
    else s4_pf_nxt = {s3_sign_r, s4_mag};
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_pf_r  <= s4_pf_nxt;
      s4_ctl_r <= s3_ctl_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: float product to int32, rounding half away from zero and
  // saturating. A NaN product gives zero.
  // ---------------------------------------------------------------------------
  logic [7:0]         s5_fe, s5_lsh, s5_k;
  logic [23:0]        s5_sig;
  logic [31:0]        s5_mag;
  logic               s5_nan;
  logic signed [31:0] s5_t_nxt, s5_t_r;
  logic [31:0]        s5_pf_r;
  aqd_pkg::ctl_t      s5_ctl_r;

  always_comb begin
    s5_fe  = s4_pf_r[30:23];
    s5_sig = {1'b1, s4_pf_r[22:0]};
    s5_nan = (s5_fe == 8'hFF) && (s4_pf_r[22:0] != 23'd0);
    s5_lsh = s5_fe - 8'd150;
    s5_k   = 8'd150 - s5_fe;
    s5_mag = '0;
    if (s5_nan || s5_fe < 8'd126) begin
      s5_t_nxt = '0;
    end else if (s5_fe >= 8'd158) begin
      s5_t_nxt = s4_pf_r[31] ? aqd_pkg::INT32_MIN : aqd_pkg::INT32_MAX;
    end else begin
      if (s5_fe >= 8'd150) s5_mag = {8'd0, s5_sig} << s5_lsh[2:0];
      else s5_mag = ({8'd0, s5_sig} >> s5_k[4:0]) + {31'd0, s5_sig[s5_k[4:0] - 5'd1]};
      s5_t_nxt = s4_pf_r[31] ? $signed(32'd0 - s5_mag) : $signed(s5_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      s5_t_r   <= s5_t_nxt;
      s5_pf_r  <= s4_pf_r;
      s5_ctl_r <= s4_ctl_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: add the zero point at full width, clamp to the target range and
  // choose the result word. This is the output register.
  // ---------------------------------------------------------------------------
  logic signed [32:0] s6_sum, s6_lo, s6_hi, s6_cl;
  logic               s6_clamp;
  aqd_pkg::out_word_t s6_out_nxt, out_data_r;

  always_comb begin
    s6_sum   = $signed({s5_t_r[31], s5_t_r}) + $signed({{17{zp_r[15]}}, zp_r});
    s6_lo    = s5_ctl_r.wide ? aqd_pkg::Q16_LO : aqd_pkg::Q8_LO;
    s6_hi    = s5_ctl_r.wide ? aqd_pkg::Q16_HI : aqd_pkg::Q8_HI;
    s6_clamp = 1'b0;
    s6_cl    = s6_sum;
    if (s6_sum < s6_lo) begin
      s6_cl    = s6_lo;
      s6_clamp = 1'b1;
    end else if (s6_sum > s6_hi) begin
      s6_cl    = s6_hi;
      s6_clamp = 1'b1;
    end
    s6_out_nxt.last_out = s5_ctl_r.last;
    if (s5_ctl_r.dq) begin
      s6_out_nxt.result_bits = s5_pf_r;
      s6_out_nxt.scale_error = 1'b0;
      s6_out_nxt.was_clamped = 1'b0;
    end else if (s5_ctl_r.err) begin
      s6_out_nxt.result_bits = '0;
      s6_out_nxt.scale_error = 1'b1;
      s6_out_nxt.was_clamped = 1'b0;
    end else begin
      s6_out_nxt.result_bits = s6_cl[31:0];
      s6_out_nxt.scale_error = 1'b0;
      s6_out_nxt.was_clamped = s6_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (adv6) out_data_r <= s6_out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `AQD_ASSERT_NOW(a_err_gives_zero, out_valid && out_data.scale_error, out_data.result_bits == 32'd0 && !out_data.was_clamped)
  `AQD_ASSERT_NEXT(a_accept_fills_stage1, in_valid && !in_stall, v1_r)
  `AQD_ASSERT_NOW(a_stall_only_when_full, in_stall, v1_r && v2_r && v3_r && v4_r && v5_r && out_valid_r)

endmodule
